@@ sv/pgtp_pkg.sv @@
package pgtp_pkg;

   localparam int COORD_W = 5;
   localparam int EDGE_W = 5;
   localparam int DATA_W = 32;
   localparam int COEF_W = 7;
   localparam int STEP_W = 5;
   localparam int RND_SHIFT = 5;
   localparam int ROUND_HALF = 16;

   localparam logic [EDGE_W-1:0] EDGE_MIN = 5'd2;
   localparam logic [EDGE_W-1:0] GRID_EDGE_RST = 5'd16;
   localparam logic ORDER_MODE_RST = 1'b1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic CSR_GRID_EDGE = 1'b0;
   localparam logic CSR_ORDER_MODE = 1'b1;

   localparam logic [STEP_W-1:0] STEP_LAST_FIRST = 5'd6;
   localparam logic [STEP_W-1:0] STEP_LAST = 5'd18;

   localparam logic signed [COEF_W-1:0] COEF_CENTER1 = 7'sd32;
   localparam logic signed [COEF_W-1:0] COEF_CENTER2 = 7'sd20;
   localparam logic signed [COEF_W-1:0] COEF_FACE = 7'sd4;
   localparam logic signed [COEF_W-1:0] COEF_CURV = 7'sd2;
   localparam logic signed [COEF_W-1:0] COEF_EDGE = 7'sd1;

   typedef enum logic [1:0] {OFS_ZERO, OFS_PLUS, OFS_MINUS} ofs_type;
   typedef enum logic [1:0] {KIND_CENTER, KIND_FACE, KIND_EDGE} kind_type;
   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_type;

   typedef struct packed {
      ofs_type dx;
      ofs_type dy;
      ofs_type dz;
      kind_type kind;
      logic end_first;
      logic end_all;
   } ucode_type;

   typedef struct packed {
      logic latch;
      logic issue;
      ucode_type uc;
   } seq_ctl_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } cell_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic sat;
      logic err;
   } res_type;

   // The program reads the parent, then its face neighbors and then the edge
   // neighbors of the three planes. First order stops after the faces.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type u;
      u = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, KIND_CENTER, 1'b0, 1'b1};
      case (step)
         5'd0: u = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, KIND_CENTER, 1'b0, 1'b0};
         5'd1: u = '{OFS_PLUS, OFS_ZERO, OFS_ZERO, KIND_FACE, 1'b0, 1'b0};
         5'd2: u = '{OFS_MINUS, OFS_ZERO, OFS_ZERO, KIND_FACE, 1'b0, 1'b0};
         5'd3: u = '{OFS_ZERO, OFS_PLUS, OFS_ZERO, KIND_FACE, 1'b0, 1'b0};
         5'd4: u = '{OFS_ZERO, OFS_MINUS, OFS_ZERO, KIND_FACE, 1'b0, 1'b0};
         5'd5: u = '{OFS_ZERO, OFS_ZERO, OFS_PLUS, KIND_FACE, 1'b0, 1'b0};
         5'd6: u = '{OFS_ZERO, OFS_ZERO, OFS_MINUS, KIND_FACE, 1'b1, 1'b0};
         5'd7: u = '{OFS_PLUS, OFS_PLUS, OFS_ZERO, KIND_EDGE, 1'b0, 1'b0};
         5'd8: u = '{OFS_PLUS, OFS_MINUS, OFS_ZERO, KIND_EDGE, 1'b0, 1'b0};
         5'd9: u = '{OFS_MINUS, OFS_PLUS, OFS_ZERO, KIND_EDGE, 1'b0, 1'b0};
         5'd10: u = '{OFS_MINUS, OFS_MINUS, OFS_ZERO, KIND_EDGE, 1'b0, 1'b0};
         5'd11: u = '{OFS_PLUS, OFS_ZERO, OFS_PLUS, KIND_EDGE, 1'b0, 1'b0};
         5'd12: u = '{OFS_PLUS, OFS_ZERO, OFS_MINUS, KIND_EDGE, 1'b0, 1'b0};
         5'd13: u = '{OFS_MINUS, OFS_ZERO, OFS_PLUS, KIND_EDGE, 1'b0, 1'b0};
         5'd14: u = '{OFS_MINUS, OFS_ZERO, OFS_MINUS, KIND_EDGE, 1'b0, 1'b0};
         5'd15: u = '{OFS_ZERO, OFS_PLUS, OFS_PLUS, KIND_EDGE, 1'b0, 1'b0};
         5'd16: u = '{OFS_ZERO, OFS_PLUS, OFS_MINUS, KIND_EDGE, 1'b0, 1'b0};
         5'd17: u = '{OFS_ZERO, OFS_MINUS, OFS_PLUS, KIND_EDGE, 1'b0, 1'b0};
         5'd18: u = '{OFS_ZERO, OFS_MINUS, OFS_MINUS, KIND_EDGE, 1'b0, 1'b1};
         default: u = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, KIND_CENTER, 1'b0, 1'b1};
      endcase
      return u;
   endfunction

endpackage

@@ sv/pgtp_ram.sv @@
module pgtp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/pgtp_seq.sv @@
module pgtp_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  start_err,
   input  logic                  order_mode,
   input  logic                  rsp_free,
   output pgtp_pkg::seq_ctl_type ctl,
   output logic                  idle,
   output logic                  done
);

   import pgtp_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              drain_ff, drain_in;
   ucode_type         uc;
   logic              uc_end;

   assign uc = ucode_rom(step_ff);
   assign uc_end = uc.end_all || (uc.end_first && !order_mode);

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      drain_in = drain_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               step_in = '0;
               state_in = start_err ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            if (uc_end) begin
               state_in = ST_DRAIN;
               drain_in = 1'b0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl = '0;
      ctl.uc = uc;
      ctl.latch = (state_ff == ST_IDLE) && start;
      ctl.issue = (state_ff == ST_RUN);
      idle = (state_ff == ST_IDLE);
      done = (state_ff == ST_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         drain_ff <= drain_in;
      end
   end

   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (step_ff <= STEP_LAST))
      else $error("Step counter ran past the end of the program.");

   a_first_order_short: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && !order_mode) |-> (step_ff <= STEP_LAST_FIRST))
      else $error("First-order program ran past the face neighbors.");

   a_run_leaves_to_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |=> (state_ff == ST_RUN || state_ff == ST_DRAIN))
      else $error("Program left the run state other than through the drain.");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !rsp_free) |=> (state_ff == ST_DONE))
      else $error("Result was dropped while the output register was full.");

endmodule

@@ sv/pgtp_alu.sv @@
module pgtp_alu #(
   parameter int SAMPLE_W = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pgtp_pkg::seq_ctl_type             ctl,
   input  logic                              order_mode,
   input  logic [pgtp_pkg::EDGE_W-1:0]       edge_n,
   input  logic [pgtp_pkg::COORD_W-1:0]      q_x,
   input  logic [pgtp_pkg::COORD_W-1:0]      q_y,
   input  logic [pgtp_pkg::COORD_W-1:0]      q_z,
   input  logic                              q_err,
   input  logic [SAMPLE_W-1:0]               rd_data,
   output pgtp_pkg::cell_type                rd_cell,
   output pgtp_pkg::res_type                 res
);

   import pgtp_pkg::*;

   localparam int PROD_W = SAMPLE_W + COEF_W;
   localparam int ACC_W = SAMPLE_W + 8;
   localparam int R_W = ACC_W - RND_SHIFT;

   logic [COORD_W-1:0]        px_ff, py_ff, pz_ff, nm1_ff;
   logic                      ox_ff, oy_ff, oz_ff, err_ff;
   logic signed [COEF_W-1:0]  coef_in, coef_ff;
   logic                      vld1_ff, vld2_ff;
   logic signed [PROD_W-1:0]  prod_in, prod_ff;
   logic signed [ACC_W-1:0]   acc_in, acc_ff;
   logic signed [ACC_W-1:0]   rsum;
   logic [R_W-1:0]            rnd;
   logic [R_W-SAMPLE_W:0]     top_bits;
   logic                      in_range;
   logic [SAMPLE_W-1:0]       clip;
   logic                      neg;

   function automatic logic [COORD_W-1:0] pick(input ofs_type o,
                                               input logic [COORD_W-1:0] p,
                                               input logic [COORD_W-1:0] nm1);
      logic [COORD_W-1:0] r;
      case (o)
         OFS_PLUS: r = (p == nm1) ? '0 : p + 1'b1;
         OFS_MINUS: r = (p == '0) ? nm1 : p - 1'b1;
         default: r = p;
      endcase
      return r;
   endfunction

   function automatic logic neg_of(input ofs_type o, input logic odd);
      return (o != OFS_ZERO) && !(odd ^ (o == OFS_MINUS));
   endfunction

   always_comb begin
      rd_cell.x = pick(ctl.uc.dx, px_ff, nm1_ff);
      rd_cell.y = pick(ctl.uc.dy, py_ff, nm1_ff);
      rd_cell.z = pick(ctl.uc.dz, pz_ff, nm1_ff);
   end

   assign neg = neg_of(ctl.uc.dx, ox_ff) ^ neg_of(ctl.uc.dy, oy_ff)
              ^ neg_of(ctl.uc.dz, oz_ff);

   always_comb begin
      case (ctl.uc.kind)
         KIND_CENTER: coef_in = order_mode ? COEF_CENTER2 : COEF_CENTER1;
         KIND_FACE: coef_in = (neg ? -COEF_FACE : COEF_FACE)
                            + (order_mode ? COEF_CURV : '0);
         KIND_EDGE: coef_in = neg ? -COEF_EDGE : COEF_EDGE;
         default: coef_in = '0;
      endcase
   end

   assign prod_in = $signed(rd_data) * coef_ff;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.latch) begin
         acc_in = '0;
      end else if (vld2_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         px_ff <= {1'b0, q_x[COORD_W-1:1]};
         py_ff <= {1'b0, q_y[COORD_W-1:1]};
         pz_ff <= {1'b0, q_z[COORD_W-1:1]};
         ox_ff <= q_x[0];
         oy_ff <= q_y[0];
         oz_ff <= q_z[0];
         nm1_ff <= edge_n - EDGE_W'(1);
         err_ff <= q_err;
      end
      coef_ff <= coef_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= ctl.issue;
         vld2_ff <= vld1_ff;
      end
   end

   assign rsum = acc_ff + ACC_W'(ROUND_HALF);
   assign rnd = rsum[ACC_W-1:RND_SHIFT];
   assign top_bits = rnd[R_W-1:SAMPLE_W-1];
   assign in_range = (top_bits == '0) || (top_bits == '1);

   always_comb begin
      if (in_range) begin
         clip = rnd[SAMPLE_W-1:0];
      end else if (rnd[R_W-1]) begin
         clip = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         clip = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   always_comb begin
      res = '0;
      if (err_ff) begin
         res.err = 1'b1;
      end else begin
         res.value = DATA_W'($signed(clip));
         res.sat = !in_range;
      end
   end

endmodule

@@ sv/periodic_grid_taylor_prolongation.sv @@
// Channel   Direction  Beat contents
// req_      in         opcode, coord_x, coord_y, coord_z, sample
// rsp_      out        fine_value, saturated, range_error (one beat per query)
// csr_      in         wr_en, index, wr_data (write only, no wait)
//
// A load writes the grid memory at the edge it is accepted.
// A query reads the single-port grid memory once per program step; a first-order
// query stops after the face neighbors, so it runs a shorter program.
// A query with an out-of-range coordinate skips the program and returns an error beat.
// Reset sets the registers to edge 16 and second order; grid contents stay
// undefined until loaded. A stalled result holds the block in its final step.
module periodic_grid_taylor_prolongation #(
   parameter int MAX_EDGE = 16,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [pgtp_pkg::COORD_W-1:0]      req_coord_x,
   input  logic [pgtp_pkg::COORD_W-1:0]      req_coord_y,
   input  logic [pgtp_pkg::COORD_W-1:0]      req_coord_z,
   input  logic signed [pgtp_pkg::DATA_W-1:0] req_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [pgtp_pkg::DATA_W-1:0] rsp_fine_value,
   output logic                              rsp_saturated,
   output logic                              rsp_range_error,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [pgtp_pkg::EDGE_W-1:0]       csr_wr_data
);

   import pgtp_pkg::*;

   localparam int EFF_SW = (SAMPLE_WIDTH < DATA_W) ? SAMPLE_WIDTH : DATA_W;
   localparam int DEPTH = MAX_EDGE * MAX_EDGE * MAX_EDGE;
   localparam int AW = $clog2(DEPTH);

   logic [EDGE_W-1:0]   grid_edge_ff, grid_edge_in;
   logic                order_ff, order_in;
   logic [EDGE_W-1:0]   edge_n;
   logic                accept, start, q_err, load_we;
   logic                seq_idle, seq_done, rsp_free;
   seq_ctl_type         ctl;
   cell_type            rd_cell, ram_cell;
   logic [AW-1:0]       ram_addr;
   logic [EFF_SW-1:0]   ram_rdata;
   res_type             res;
   logic                rsp_valid_ff, rsp_valid_in;
   res_type             rsp_ff;

   always_comb begin
      grid_edge_in = grid_edge_ff;
      order_in = order_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_EDGE: grid_edge_in = csr_wr_data;
            CSR_ORDER_MODE: order_in = csr_wr_data[0];
            default: grid_edge_in = grid_edge_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_edge_ff <= GRID_EDGE_RST;
         order_ff <= ORDER_MODE_RST;
      end else begin
         grid_edge_ff <= grid_edge_in;
         order_ff <= order_in;
      end
   end

   always_comb begin
      if (grid_edge_ff < EDGE_MIN) begin
         edge_n = EDGE_MIN;
      end else if (int'(grid_edge_ff) > MAX_EDGE) begin
         edge_n = EDGE_W'(MAX_EDGE);
      end else begin
         edge_n = grid_edge_ff;
      end
   end

   assign q_err = ({1'b0, req_coord_x} >= {edge_n, 1'b0})
               || ({1'b0, req_coord_y} >= {edge_n, 1'b0})
               || ({1'b0, req_coord_z} >= {edge_n, 1'b0});

   assign req_ready = seq_idle;
   assign accept = req_valid && req_ready;
   assign start = accept && (req_opcode == OP_QUERY);
   assign load_we = accept && (req_opcode == OP_LOAD)
                 && (int'(req_coord_x) < MAX_EDGE)
                 && (int'(req_coord_y) < MAX_EDGE)
                 && (int'(req_coord_z) < MAX_EDGE);

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   pgtp_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .start_err  (q_err),
      .order_mode (order_ff),
      .rsp_free   (rsp_free),
      .ctl        (ctl),
      .idle       (seq_idle),
      .done       (seq_done)
   );

   pgtp_alu #(
      .SAMPLE_W (EFF_SW)
   ) u_alu (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .order_mode (order_ff),
      .edge_n     (edge_n),
      .q_x        (req_coord_x),
      .q_y        (req_coord_y),
      .q_z        (req_coord_z),
      .q_err      (q_err),
      .rd_data    (ram_rdata),
      .rd_cell    (rd_cell),
      .res        (res)
   );

   always_comb begin
      if (seq_idle) begin
         ram_cell = '{req_coord_x, req_coord_y, req_coord_z};
      end else begin
         ram_cell = rd_cell;
      end
   end

   assign ram_addr = AW'(ram_cell.x) * AW'(MAX_EDGE * MAX_EDGE)
                   + AW'(ram_cell.y) * AW'(MAX_EDGE)
                   + AW'(ram_cell.z);

   pgtp_ram #(
      .WIDTH (EFF_SW),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock (clock),
      .we    (load_we),
      .addr  (ram_addr),
      .wdata (req_sample[EFF_SW-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (seq_done && rsp_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_done && rsp_free) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_fine_value = rsp_ff.value;
   assign rsp_saturated = rsp_ff.sat;
   assign rsp_range_error = rsp_ff.err;

endmodule

@@ tb/sv/prolongation_monitor.sv @@
`timescale 1ns / 1ps

module prolongation_monitor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [pgtp_pkg::COORD_W-1:0]       req_coord_x,
   input  logic [pgtp_pkg::COORD_W-1:0]       req_coord_y,
   input  logic [pgtp_pkg::COORD_W-1:0]       req_coord_z,
   input  logic signed [pgtp_pkg::DATA_W-1:0] req_sample,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [pgtp_pkg::DATA_W-1:0] rsp_fine_value,
   input  logic                              rsp_saturated,
   input  logic                              rsp_range_error,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [pgtp_pkg::EDGE_W-1:0]        csr_wr_data,
   output int                                mismatches,
   output int                                pending
);

   import pgtp_pkg::*;

   localparam int GRID_MAX = 16;
   localparam longint VALUE_HI = (longint'(1) <<< (DATA_W - 1)) - 1;
   localparam longint VALUE_LO = -VALUE_HI - 1;

   logic signed [DATA_W-1:0] coarse_mem [GRID_MAX*GRID_MAX*GRID_MAX];
   logic [EDGE_W-1:0] edge_cfg = GRID_EDGE_RST;
   logic order_cfg = ORDER_MODE_RST;
   res_type fine_expect_q [$];

   function automatic longint coarse_at(input int x, input int y, input int z);
      return longint'(coarse_mem[(x * GRID_MAX + y) * GRID_MAX + z]);
   endfunction

   function automatic res_type prolong(input logic [COORD_W-1:0] fx,
                                       input logic [COORD_W-1:0] fy,
                                       input logic [COORD_W-1:0] fz);
      int n, qx, qy, qz, px, py, pz, xp, xm, yp, ym, zp, zm;
      longint sx, sy, sz, c, acc, r;
      res_type res;
      n = (edge_cfg < EDGE_MIN) ? int'(EDGE_MIN) :
          (edge_cfg > GRID_MAX) ? GRID_MAX : int'(edge_cfg);
      qx = fx;
      qy = fy;
      qz = fz;
      res = '0;
      if (qx >= 2 * n || qy >= 2 * n || qz >= 2 * n) begin
         res.err = 1'b1;
         return res;
      end
      px = qx >> 1;
      py = qy >> 1;
      pz = qz >> 1;
      sx = fx[0] ? 1 : -1;
      sy = fy[0] ? 1 : -1;
      sz = fz[0] ? 1 : -1;
      xp = (px == n - 1) ? 0 : px + 1;
      xm = (px == 0) ? n - 1 : px - 1;
      yp = (py == n - 1) ? 0 : py + 1;
      ym = (py == 0) ? n - 1 : py - 1;
      zp = (pz == n - 1) ? 0 : pz + 1;
      zm = (pz == 0) ? n - 1 : pz - 1;
      c = coarse_at(px, py, pz);
      acc = 32 * c
          + 4 * sx * (coarse_at(xp, py, pz) - coarse_at(xm, py, pz))
          + 4 * sy * (coarse_at(px, yp, pz) - coarse_at(px, ym, pz))
          + 4 * sz * (coarse_at(px, py, zp) - coarse_at(px, py, zm));
      if (order_cfg) begin
         acc += 2 * (coarse_at(xp, py, pz) + coarse_at(xm, py, pz) - 2 * c)
              + 2 * (coarse_at(px, yp, pz) + coarse_at(px, ym, pz) - 2 * c)
              + 2 * (coarse_at(px, py, zp) + coarse_at(px, py, zm) - 2 * c);
         acc += sx * sy * (coarse_at(xp, yp, pz) - coarse_at(xp, ym, pz)
                           - coarse_at(xm, yp, pz) + coarse_at(xm, ym, pz));
         acc += sx * sz * (coarse_at(xp, py, zp) - coarse_at(xp, py, zm)
                           - coarse_at(xm, py, zp) + coarse_at(xm, py, zm));
         acc += sy * sz * (coarse_at(px, yp, zp) - coarse_at(px, ym, zp)
                           - coarse_at(px, yp, zm) + coarse_at(px, ym, zm));
      end
      // The arithmetic shift floors, so adding one half rounds ties upward.
      r = (acc + ROUND_HALF) >>> RND_SHIFT;
      if (r > VALUE_HI) begin
         r = VALUE_HI;
         res.sat = 1'b1;
      end
      if (r < VALUE_LO) begin
         r = VALUE_LO;
         res.sat = 1'b1;
      end
      res.value = r[DATA_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin : watch
      res_type want;
      logic bad;
      if (reset) begin
         edge_cfg <= GRID_EDGE_RST;
         order_cfg <= ORDER_MODE_RST;
         fine_expect_q.delete();
         pending <= 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_GRID_EDGE) begin
               edge_cfg <= csr_wr_data;
            end else begin
               order_cfg <= csr_wr_data[0];
            end
         end
         if (req_valid && req_ready) begin
            if (req_opcode == OP_LOAD) begin
               if (req_coord_x < GRID_MAX && req_coord_y < GRID_MAX &&
                   req_coord_z < GRID_MAX) begin
                  coarse_mem[(int'(req_coord_x) * GRID_MAX + int'(req_coord_y)) * GRID_MAX
                             + int'(req_coord_z)] <= req_sample;
               end
            end else begin
               fine_expect_q.push_back(prolong(req_coord_x, req_coord_y, req_coord_z));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (fine_expect_q.size() == 0) begin
               $display("%0t: result beat with nothing expected: value %0d sat %0b err %0b",
                        $time, rsp_fine_value, rsp_saturated, rsp_range_error);
               mismatches <= mismatches + 1;
            end else begin
               want = fine_expect_q.pop_front();
               bad = 1'b0;
               if (rsp_fine_value !== want.value) begin
                  $display("%0t: fine_value expected %0d actual %0d", $time,
                           $signed(want.value), rsp_fine_value);
                  bad = 1'b1;
               end
               if (rsp_saturated !== want.sat) begin
                  $display("%0t: saturated expected %0b actual %0b", $time,
                           want.sat, rsp_saturated);
                  bad = 1'b1;
               end
               if (rsp_range_error !== want.err) begin
                  $display("%0t: range_error expected %0b actual %0b", $time,
                           want.err, rsp_range_error);
                  bad = 1'b1;
               end
               if (bad) begin
                  mismatches <= mismatches + 1;
               end
            end
         end
         pending <= fine_expect_q.size();
      end
   end

endmodule

@@ tb/sv/periodic_grid_taylor_prolongation_test.sv @@
`timescale 1ns / 1ps

module periodic_grid_taylor_prolongation_test;
   import pgtp_pkg::*;

   localparam int GRID_MAX = 16;
   localparam int DRAIN_CYCLES = 40;
   localparam int BEAT_TARGET = 1150;
   localparam int PHASE_BEATS = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_opcode = OP_LOAD;
   logic [COORD_W-1:0] req_coord_x = '0;
   logic [COORD_W-1:0] req_coord_y = '0;
   logic [COORD_W-1:0] req_coord_z = '0;
   logic signed [DATA_W-1:0] req_sample = '0;
   logic rsp_ready = 1'b0;
   logic csr_wr_en = 1'b0;
   logic csr_index = CSR_GRID_EDGE;
   logic [EDGE_W-1:0] csr_wr_data = '0;
   logic req_ready;
   logic rsp_valid;
   logic signed [DATA_W-1:0] rsp_fine_value;
   logic rsp_saturated;
   logic rsp_range_error;

   int mismatches;
   int pending;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int beats_sent = 0;
   int edge_now = GRID_MAX;
   bit loaded [GRID_MAX*GRID_MAX*GRID_MAX];

   periodic_grid_taylor_prolongation dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_fine_value(rsp_fine_value),
      .rsp_saturated(rsp_saturated), .rsp_range_error(rsp_range_error),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   prolongation_monitor u_monitor (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_fine_value(rsp_fine_value),
      .rsp_saturated(rsp_saturated), .rsp_range_error(rsp_range_error),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .mismatches(mismatches), .pending(pending)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      #(10_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [DATA_W-1:0] random_sample();
      case ($urandom_range(3))
         0: return $urandom_range(1) ? {1'b0, {(DATA_W-1){1'b1}}} : {1'b1, {(DATA_W-1){1'b0}}};
         1: return $urandom;
         default: return $urandom_range(1 << 20) - (1 << 19);
      endcase
   endfunction

   task automatic send_beat(input logic op, input int x, input int y, input int z,
                            input logic [DATA_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_coord_x <= x[COORD_W-1:0];
      req_coord_y <= y[COORD_W-1:0];
      req_coord_z <= z[COORD_W-1:0];
      req_sample <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      if (op == OP_LOAD && x < GRID_MAX && y < GRID_MAX && z < GRID_MAX) begin
         loaded[(x * GRID_MAX + y) * GRID_MAX + z] = 1'b1;
      end
   endtask

   // Every coarse cell that the query can read is loaded first.
   task automatic query_fine(input int x, input int y, input int z);
      int cx, cy, cz;
      if (x < 2 * edge_now && y < 2 * edge_now && z < 2 * edge_now) begin
         for (int dx = -1; dx <= 1; dx++) begin
            for (int dy = -1; dy <= 1; dy++) begin
               for (int dz = -1; dz <= 1; dz++) begin
                  if (dx * dx + dy * dy + dz * dz < 3) begin
                     cx = (x / 2 + dx + edge_now) % edge_now;
                     cy = (y / 2 + dy + edge_now) % edge_now;
                     cz = (z / 2 + dz + edge_now) % edge_now;
                     if (!loaded[(cx * GRID_MAX + cy) * GRID_MAX + cz]) begin
                        send_beat(OP_LOAD, cx, cy, cz, random_sample());
                     end
                  end
               end
            end
         end
      end
      send_beat(OP_QUERY, x, y, z, $urandom);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [EDGE_W-1:0] edge_val, input logic order_val);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_GRID_EDGE;
      csr_wr_data <= edge_val;
      @(posedge clock);
      csr_index <= CSR_ORDER_MODE;
      csr_wr_data <= {{(EDGE_W-1){1'b0}}, order_val};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      edge_now = (edge_val < EDGE_MIN) ? int'(EDGE_MIN) :
                 (edge_val > GRID_MAX) ? GRID_MAX : int'(edge_val);
   endtask

   task automatic set_idle_mode(input int mode);
      case (mode)
         0: begin send_idle_pct = 0; recv_stall_pct = 0; end
         1: begin send_idle_pct = 83; recv_stall_pct = 0; end
         2: begin send_idle_pct = 0; recv_stall_pct = 83; end
         default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
   endtask

   initial begin : stimulus
      int phase;
      int pick;
      int axis;
      int fx, fy, fz;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Loads beyond the physical store are dropped.
      send_beat(OP_LOAD, 16, 3, 3, {1'b0, {(DATA_W-1){1'b1}}});
      send_beat(OP_LOAD, 3, 31, 3, {1'b1, {(DATA_W-1){1'b0}}});
      send_beat(OP_LOAD, 31, 31, 31, '1);
      query_fine(31, 0, 31);

      // An edge below the minimum is clamped to two cells.
      apply_setting(5'd0, 1'b1);
      send_beat(OP_LOAD, 0, 0, 0, {1'b0, {(DATA_W-1){1'b1}}});
      send_beat(OP_LOAD, 1, 0, 0, {1'b1, {(DATA_W-1){1'b0}}});
      query_fine(1, 0, 0);
      query_fine(3, 3, 3);
      query_fine(4, 0, 0);

      apply_setting(5'd3, 1'b0);
      send_beat(OP_LOAD, 1, 1, 1, {1'b0, {(DATA_W-1){1'b1}}});
      send_beat(OP_LOAD, 2, 1, 1, {1'b0, {(DATA_W-1){1'b1}}});
      send_beat(OP_LOAD, 0, 1, 1, {1'b1, {(DATA_W-1){1'b0}}});
      query_fine(3, 2, 2);
      query_fine(0, 6, 0);
      query_fine(5, 5, 0);

      // An edge above the maximum is clamped to the full store.
      apply_setting(5'd31, 1'b1);
      query_fine(0, 0, 1);

      phase = 0;
      while (beats_sent < BEAT_TARGET) begin
         case ($urandom_range(3))
            0: apply_setting(5'd2, 1'($urandom_range(1)));
            1: apply_setting(5'd16, 1'($urandom_range(1)));
            2: apply_setting(5'($urandom_range(31)), 1'($urandom_range(1)));
            default: apply_setting(5'($urandom_range(2, 8)), 1'($urandom_range(1)));
         endcase
         set_idle_mode(phase % 4);
         phase++;
         repeat (PHASE_BEATS) begin
            if (beats_sent >= BEAT_TARGET) break;
            pick = $urandom_range(99);
            if (pick < 80 || (pick < 90 && edge_now == GRID_MAX)) begin
               query_fine($urandom_range(2 * edge_now - 1), $urandom_range(2 * edge_now - 1),
                          $urandom_range(2 * edge_now - 1));
            end else if (pick < 90) begin
               fx = $urandom_range(31);
               fy = $urandom_range(31);
               fz = $urandom_range(31);
               axis = $urandom_range(2);
               if (axis == 0) fx = $urandom_range(2 * edge_now, 31);
               else if (axis == 1) fy = $urandom_range(2 * edge_now, 31);
               else fz = $urandom_range(2 * edge_now, 31);
               query_fine(fx, fy, fz);
            end else begin
               send_beat(OP_LOAD, $urandom_range(31), $urandom_range(31), $urandom_range(31),
                         random_sample());
            end
         end
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
